/* rtl/core/wrs_pkg.sv */
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types and codes of the reassociation sequencer: event and command
// codes, phase encoding and the command run passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package wrs_pkg;

  localparam int unsigned RUN_MAX     = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;

  typedef enum logic [2:0] {
    ACT_START      = 3'd0,
    ACT_CFG_DONE   = 3'd1,
    ACT_TX_DONE    = 3'd2,
    ACT_RX_FRAME   = 3'd3,
    ACT_TIMEOUT    = 3'd4,
    ACT_PUSH_POSS  = 3'd5,
    ACT_LEAVE      = 3'd6
  } action_e;

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_QUEUE_REQ  = 4'd1,
    CMD_FREE_TX    = 4'd2,
    CMD_FREE_RX    = 4'd3,
    CMD_START_TMR  = 4'd4,
    CMD_CANCEL_TMR = 4'd5,
    CMD_PARSE_AC   = 4'd6,
    CMD_CONFIG_AC  = 4'd7,
    CMD_DISASSOC   = 4'd8,
    CMD_FORWARD    = 4'd9,
    CMD_DATA_DONE  = 4'd10,
    CMD_MGMT_DONE  = 4'd11,
    CMD_GO_INFRA   = 4'd12,
    CMD_GO_IDLE    = 4'd13,
    CMD_ERROR      = 4'd14
  } cmd_e;

  typedef enum logic [4:0] {
    PH_INIT     = 5'b00001,
    PH_TXREQ    = 5'b00010,
    PH_WAITRESP = 5'b00100,
    PH_CONFAC   = 5'b01000,
    PH_WAITPUSH = 5'b10000
  } phase_e;

  localparam logic [1:0] PKT_USER_DATA = 2'd0;
  localparam logic [1:0] PKT_MGMT_PATH = 2'd1;
  localparam logic [1:0] PKT_REASSOC   = 2'd2;

  localparam logic [1:0] FRM_CLASS3    = 2'd1;
  localparam logic [1:0] FRM_REASSOC   = 2'd2;

  localparam logic [1:0] COMP_NONE     = 2'd0;
  localparam logic [1:0] COMP_DENIED   = 2'd1;
  localparam logic [1:0] COMP_TIMEOUT  = 2'd2;

  localparam logic [1:0] REG_QOS       = 2'd0;
  localparam logic [1:0] REG_ASSOC     = 2'd1;
  localparam logic [1:0] REG_WMM_CNT   = 2'd2;

  // One event's command run; code and status belong to a go-idle command.
  typedef struct packed {
    logic [RUN_MAX-1:0][3:0] cmds;
    logic [1:0]              last_idx;
    logic [1:0]              code;
    logic [15:0]             status;
  } run_t;

endpackage

`default_nettype wire

/* rtl/core/wlan_reassociation_sequencer_top.sv */
// ----------------------------------------------------------------------------
// wlan_reassociation_sequencer_top
// Flow: an accepted event's run is written into the run queue; the issuer then
//   loads its commands (up to four) into the output register in order.
// Throughput: one event per cycle into the run queue while it is not full;
//   sustained rate is set by the issuer, one command per cycle while unstalled.
// Reset: rst_ni clears phase, flags, held denial status, queue and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module wlan_reassociation_sequencer_top
  import wrs_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        action_i,
  input  wire logic [1:0]        packet_kind_i,
  input  wire logic              tx_accepted_i,
  input  wire logic              rx_ok_i,
  input  wire logic              to_ds_i,
  input  wire logic [1:0]        frame_kind_i,
  input  wire logic              da_group_i,
  input  wire logic              da_is_ours_i,
  input  wire logic [15:0]       resp_status_i,
  input  wire logic              wmm_present_i,
  input  wire logic [3:0]        wmm_set_count_i,
  input  wire logic              forward_ok_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [3:0]             command_o,
  output logic [1:0]             completion_code_o,
  output logic [15:0]            denial_status_o,
  output logic                   last_o
);

  logic       qos_q;
  logic       assoc_q;
  logic [3:0] wmm_cnt_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  run_t       push_run;
  run_t       head_run;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qos_q     <= 1'b0;
      assoc_q   <= 1'b0;
      wmm_cnt_q <= 4'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_QOS:     qos_q     <= pwdata[0];
        REG_ASSOC:   assoc_q   <= pwdata[0];
        REG_WMM_CNT: wmm_cnt_q <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QOS:     prdata = {{(DATA_W-1){1'b0}}, qos_q};
      REG_ASSOC:   prdata = {{(DATA_W-1){1'b0}}, assoc_q};
      REG_WMM_CNT: prdata = {{(DATA_W-4){1'b0}}, wmm_cnt_q};
      default:     prdata = '0;
    endcase
  end

  wrs_front u_front (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .action_i                (action_i),
    .packet_kind_i           (packet_kind_i),
    .tx_accepted_i           (tx_accepted_i),
    .rx_ok_i                 (rx_ok_i),
    .to_ds_i                 (to_ds_i),
    .frame_kind_i            (frame_kind_i),
    .da_group_i              (da_group_i),
    .da_is_ours_i            (da_is_ours_i),
    .resp_status_i           (resp_status_i),
    .wmm_present_i           (wmm_present_i),
    .wmm_set_count_i         (wmm_set_count_i),
    .forward_ok_i            (forward_ok_i),
    .qos_enabled_i           (qos_q),
    .station_associated_i    (assoc_q),
    .current_wmm_set_count_i (wmm_cnt_q),
    .q_full_i                (q_full),
    .push_o                  (push),
    .run_o                   (push_run)
  );

  wrs_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_run_i (push_run),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head_run)
  );

  wrs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .head_i            (head_run),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .command_o         (command_o),
    .completion_code_o (completion_code_o),
    .denial_status_o   (denial_status_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

/* rtl/core/wrs_queue.sv */
// ----------------------------------------------------------------------------
// wrs_queue
// Small FIFO of command runs between the event front end and the issuer.
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_queue
  import wrs_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  run_t      push_run_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output run_t      head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  run_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_run_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wrs_front.sv */
// ----------------------------------------------------------------------------
// wrs_front
// Event front end: accepts one event a cycle unless the queue is full, updates
// the sequencer state and builds the run of commands that the event causes.
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_front
  import wrs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [1:0]  packet_kind_i,
  input  wire logic        tx_accepted_i,
  input  wire logic        rx_ok_i,
  input  wire logic        to_ds_i,
  input  wire logic [1:0]  frame_kind_i,
  input  wire logic        da_group_i,
  input  wire logic        da_is_ours_i,
  input  wire logic [15:0] resp_status_i,
  input  wire logic        wmm_present_i,
  input  wire logic [3:0]  wmm_set_count_i,
  input  wire logic        forward_ok_i,
  input  wire logic        qos_enabled_i,
  input  wire logic        station_associated_i,
  input  wire logic [3:0]  current_wmm_set_count_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output run_t             run_o
);

  phase_e      phase_q, phase_d;
  logic        resp_rcvd_q, resp_rcvd_d;
  logic        succ_q, succ_d;
  logic        pend_q, pend_d;
  logic [15:0] held_q, held_d;

  logic [2:0]  cnt;
  logic        status_zero;
  logic        parse_ac;
  logic        accept;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept;

  assign status_zero = (resp_status_i == 16'd0);
  assign parse_ac    = status_zero && qos_enabled_i && wmm_present_i &&
                       (wmm_set_count_i != current_wmm_set_count_i);

  always_comb begin
    phase_d     = phase_q;
    resp_rcvd_d = resp_rcvd_q;
    succ_d      = succ_q;
    pend_d      = pend_q;
    held_d      = held_q;
    run_o       = '0;
    cnt         = 3'd0;

    case (action_i)
      ACT_START, ACT_CFG_DONE: begin
        if (action_i == ACT_START && phase_q == PH_INIT) begin
          resp_rcvd_d = 1'b0;
          succ_d      = 1'b0;
          pend_d      = 1'b0;
          held_d      = 16'd0;
          if (tx_accepted_i) begin
            phase_d = PH_TXREQ;
            run_o.cmds[0] = CMD_QUEUE_REQ;
          end else begin
            phase_d = PH_WAITPUSH;
            run_o.cmds[0] = CMD_FREE_TX;
          end
          cnt = 3'd1;
        end else if (phase_q == PH_CONFAC) begin
          if (succ_q) begin
            run_o.cmds[0] = CMD_GO_INFRA;
          end else begin
            run_o.cmds[0] = CMD_GO_IDLE;
            run_o.code    = COMP_DENIED;
            run_o.status  = held_q;
          end
          phase_d = PH_INIT;
          cnt     = 3'd1;
        end else begin
          run_o.cmds[0] = CMD_ERROR;
          cnt = 3'd1;
        end
      end
      ACT_TX_DONE: begin
        case (packet_kind_i)
          PKT_USER_DATA: run_o.cmds[0] = CMD_DATA_DONE;
          PKT_MGMT_PATH: run_o.cmds[0] = CMD_MGMT_DONE;
          default:       run_o.cmds[0] = CMD_FREE_TX;
        endcase
        cnt = 3'd1;
        if (packet_kind_i == PKT_REASSOC) begin
          if (phase_q == PH_TXREQ) begin
            phase_d = PH_WAITRESP;
            run_o.cmds[1] = CMD_START_TMR;
          end else begin
            run_o.cmds[1] = CMD_ERROR;
          end
          cnt = 3'd2;
        end
      end
      ACT_RX_FRAME: begin
        if (!rx_ok_i || to_ds_i) begin
          run_o.cmds[0] = CMD_FREE_RX;
          cnt = 3'd1;
        end else if (frame_kind_i == FRM_CLASS3 && !da_group_i) begin
          // Unicast class 3 frame: freed, and disassociated if the station is not associated.
          run_o.cmds[0] = CMD_FREE_RX;
          cnt = 3'd1;
          if (!station_associated_i) begin
            run_o.cmds[1] = CMD_DISASSOC;
            cnt = 3'd2;
          end
        end else if (!(frame_kind_i == FRM_REASSOC && da_is_ours_i && !resp_rcvd_q)) begin
          run_o.cmds[0] = CMD_FREE_RX;
          cnt = 3'd1;
        end else begin
          if (parse_ac) begin
            pend_d = 1'b1;
            run_o.cmds[cnt[1:0]] = CMD_PARSE_AC;
            cnt = cnt + 3'd1;
          end
          if (!status_zero) begin
            held_d = resp_status_i;
          end
          run_o.cmds[cnt[1:0]] = CMD_FORWARD;
          cnt = cnt + 3'd1;
          // A failed forward leaves the response unconsumed.
          if (forward_ok_i) begin
            resp_rcvd_d = 1'b1;
            run_o.cmds[cnt[1:0]] = CMD_CANCEL_TMR;
            cnt = cnt + 3'd1;
            if (status_zero) begin
              succ_d = 1'b1;
            end
            if (phase_q == PH_WAITRESP) begin
              if (pend_d) begin
                phase_d = PH_CONFAC;
                run_o.cmds[cnt[1:0]] = CMD_CONFIG_AC;
              end else begin
                phase_d = PH_INIT;
                if (succ_d) begin
                  run_o.cmds[cnt[1:0]] = CMD_GO_INFRA;
                end else begin
                  run_o.cmds[cnt[1:0]] = CMD_GO_IDLE;
                  run_o.code   = COMP_DENIED;
                  run_o.status = held_d;
                end
              end
            end else begin
              run_o.cmds[cnt[1:0]] = CMD_ERROR;
            end
            cnt = cnt + 3'd1;
          end
        end
      end
      ACT_TIMEOUT: begin
        if (phase_q == PH_WAITRESP) begin
          if (succ_q) begin
            run_o.cmds[0] = CMD_GO_INFRA;
          end else begin
            run_o.cmds[0] = CMD_GO_IDLE;
            run_o.code    = COMP_TIMEOUT;
          end
          phase_d = PH_INIT;
          cnt     = 3'd1;
        end
      end
      ACT_PUSH_POSS: begin
        if (phase_q == PH_WAITPUSH) begin
          if (tx_accepted_i) begin
            phase_d = PH_TXREQ;
            run_o.cmds[0] = CMD_QUEUE_REQ;
          end else begin
            phase_d = PH_WAITPUSH;
            run_o.cmds[0] = CMD_FREE_TX;
          end
          cnt = 3'd1;
        end
      end
      ACT_LEAVE: begin
        phase_d = PH_INIT;
      end
      default: begin
      end
    endcase

    // An event without effect still reports a single no-op command.
    if (cnt == 3'd0) begin
      run_o.cmds[0] = CMD_NONE;
      cnt = 3'd1;
    end
    run_o.last_idx = 2'(cnt - 3'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_INIT;
      resp_rcvd_q <= 1'b0;
      succ_q      <= 1'b0;
      pend_q      <= 1'b0;
      held_q      <= 16'd0;
    end else if (accept) begin
      phase_q     <= phase_d;
      resp_rcvd_q <= resp_rcvd_d;
      succ_q      <= succ_d;
      pend_q      <= pend_d;
      held_q      <= held_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wrs_back.sv */
// ----------------------------------------------------------------------------
// wrs_back
// Command issuer: walks the run at the queue head and presents one command a
// cycle, while the output is not stalled, in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_back
  import wrs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  run_t             head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       command_o,
  output logic [1:0]       completion_code_o,
  output logic [15:0]      denial_status_o,
  output logic             last_o
);

  logic [1:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [3:0]  cmd_q;
  logic [1:0]  code_q;
  logic [15:0] status_q;
  logic        last_q;

  logic        load;
  logic [3:0]  cur_cmd;
  logic        cur_last;
  logic        is_idle;

  assign load     = !q_empty_i && (!valid_q || !out_stall_i);
  assign cur_cmd  = head_i.cmds[idx_q];
  assign cur_last = (idx_q == head_i.last_idx);
  assign is_idle  = (cur_cmd == CMD_GO_IDLE);
  assign pop_o    = load && cur_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q && out_stall_i;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = cur_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q    <= cur_cmd;
      code_q   <= is_idle ? head_i.code : COMP_NONE;
      status_q <= is_idle ? head_i.status : 16'd0;
      last_q   <= cur_last;
    end
  end

  assign out_valid_o       = valid_q;
  assign command_o         = cmd_q;
  assign completion_code_o = code_q;
  assign denial_status_o   = status_q;
  assign last_o            = last_q;

  // The run index never walks past the final command of the head run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> (idx_q <= head_i.last_idx))
    else $error("run index beyond final command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && cmd_q != CMD_GO_IDLE) |-> (code_q == COMP_NONE))
    else $error("completion code on a command other than go idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && code_q != COMP_DENIED) |-> (status_q == 16'd0))
    else $error("denial status without a denial");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !last_q && !out_stall_i) |=> valid_q)
    else $error("command run broken off before its final command");

endmodule

`default_nettype wire
